/* hdl/bpfa_pkg.sv */
`default_nettype none

package bpfa_pkg;

    // Map geometry
    localparam int NUM_PAGES = 4096;
    localparam int PAGE_W    = $clog2(NUM_PAGES);
    localparam int CNT_W     = PAGE_W + 1;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int NUM_WORDS = NUM_PAGES / WORD_W;
    localparam int WADDR_W   = $clog2(NUM_WORDS);

    // Opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_SCAN      = 5'b00010,
        S_APPLY     = 5'b00100,
        S_APPLY_MOD = 5'b01000,
        S_FINISH    = 5'b10000
    } state_t;

endpackage

`default_nettype wire

/* hdl/bitmap_page_frame_allocator.sv */
// Sequence: alloc scans words (32 pages each, at most ceil(min(usable_pages, 4096) / 32)),
//   then marks the run: fully covered words are written directly, partial edge words are
//   read then modified (S_APPLY_MOD); free skips the scan; zero-count items go to S_FINISH.
// Throughput: one item at a time; the map RAM read/modify/write sequence sets it.
// Reset: map reads as all used (row valid bits clear), usable_pages = 0, no
//   clearing pass; done is a one-cycle strobe and the receiver cannot stall.
`default_nettype none

module bitmap_page_frame_allocator (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // command beat
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       opcode,
    input  wire logic [bpfa_pkg::PAGE_W-1:0] page_index,
    input  wire logic [bpfa_pkg::CNT_W-1:0]  page_count,
    // result beat
    output logic                            done,
    output logic                            status,
    output logic [bpfa_pkg::PAGE_W-1:0]     first_page,
    // configuration
    input  wire logic                       usable_pages_we,
    input  wire logic [bpfa_pkg::CNT_W-1:0]  usable_pages
);

    import bpfa_pkg::*;

    localparam logic [WORD_W-1:0] ONES = '1;

    // ------------------------------------------------------------------
    // Word-level helpers for the scan.
    // ------------------------------------------------------------------
    // Count of free pages at the bottom of a word (trailing zeros).
    function automatic logic [BIT_W:0] free_low(input logic [WORD_W-1:0] u);
        logic [BIT_W:0] n;
        n = (BIT_W+1)'(WORD_W);
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (u[i])
                n = (BIT_W+1)'(i);
        end
        return n;
    endfunction

    // Count of free pages at the top of a word (leading zeros).
    function automatic logic [BIT_W:0] free_high(input logic [WORD_W-1:0] u);
        logic [BIT_W:0] n;
        n = (BIT_W+1)'(WORD_W);
        for (int i = 0; i < WORD_W; i++) begin
            if (u[i])
                n = (BIT_W+1)'(WORD_W - 1 - i);
        end
        return n;
    endfunction

    // Lowest set bit position.
    function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] r);
        logic [BIT_W-1:0] n;
        n = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (r[i])
                n = BIT_W'(i);
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic                   op_reg, op_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [PAGE_W-1:0]      rng_lo_reg, rng_lo_next;      // first page of run to mark
    logic [PAGE_W-1:0]      rng_last_reg, rng_last_next;  // last page of run to mark
    logic [WADDR_W-1:0]     word_reg, word_next;
    logic [CNT_W-1:0]       carry_reg, carry_next;        // free pages running into this word
    logic [PAGE_W-1:0]      run_start_reg, run_start_next;
    logic                   res_status_reg, res_status_next;
    logic [PAGE_W-1:0]      res_first_reg, res_first_next;
    logic                   done_reg;
    logic                   status_reg;
    logic [PAGE_W-1:0]      first_page_reg;
    logic [CNT_W-1:0]       usable_pages_reg;
    logic [NUM_WORDS-1:0]   row_valid_reg;

    // Map RAM: one bit per page, a set bit means used.
    logic [WORD_W-1:0]      map_mem [NUM_WORDS];
    logic [WORD_W-1:0]      rd_data_reg;
    logic                   rd_valid_reg;
    logic [WADDR_W-1:0]     raddr;
    logic                   mem_we;
    logic [WORD_W-1:0]      mem_wdata;

    // ------------------------------------------------------------------
    // Scan datapath
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]       limit;
    logic [WADDR_W-1:0]     last_scan_word;
    logic [PAGE_W-1:0]      limit_m1;
    logic [PAGE_W-1:0]      word_base;
    logic [WORD_W-1:0]      cur_word;
    logic [WORD_W-1:0]      used;
    logic [WORD_W-1:0]      win_p;
    logic [WORD_W-1:0]      win_r;
    logic [BIT_W:0]         low_free;
    logic [BIT_W:0]         high_free;
    logic [CNT_W:0]         run_sum;
    logic                   hit_carry;
    logic                   hit_inner;
    logic [PAGE_W-1:0]      found_start;
    logic [PAGE_W-1:0]      found_last;

    // Apply (mark / clear) datapath
    logic [BIT_W-1:0]       mask_lo;
    logic [BIT_W-1:0]       mask_hi;
    logic [WORD_W-1:0]      apply_mask;
    logic                   last_apply_word;
    logic [CNT_W:0]         free_sum;
    logic [CNT_W-1:0]       free_end;
    logic [PAGE_W-1:0]      free_last;

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign first_page = first_page_reg;

    // Clamp the usable limit to the map size.
    assign limit = (usable_pages_reg > CNT_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES)
                                                           : usable_pages_reg;
    assign limit_m1       = PAGE_W'(limit - CNT_W'(1));
    assign last_scan_word = limit_m1[PAGE_W-1:BIT_W];
    assign word_base      = {word_reg, {BIT_W{1'b0}}};

    // A row never written since reset reads as all used.
    assign cur_word = rd_valid_reg ? rd_data_reg : ONES;

    always_comb
    begin
        // Pages at or past the limit count as used in the last scanned word.
        used = cur_word;
        if ((word_reg == last_scan_word) && (limit[BIT_W-1:0] != '0))
            used = used | (ONES << limit[BIT_W-1:0]);

        // Erode the free mask by page_count: win_r[s] is set when pages
        // s .. s+count-1 of this word are all free. Only used when count < WORD_W.
        win_p = ~used;
        win_r = ONES;
        for (int j = 0; j < BIT_W; j++) begin
            if (count_reg[j])
                win_r = win_r & (win_p >> (count_reg[BIT_W-1:0] & BIT_W'((1 << j) - 1)));
            win_p = win_p & (win_p >> (1 << j));
        end
    end

    assign low_free  = free_low(used);
    assign high_free = free_high(used);
    assign run_sum   = {1'b0, carry_reg} + (CNT_W+1)'(low_free);
    assign hit_carry = (run_sum >= {1'b0, count_reg});
    assign hit_inner = (count_reg[CNT_W-1:BIT_W] == '0) && (win_r != '0);

    always_comb
    begin
        if (hit_carry)
            found_start = (carry_reg != '0) ? run_start_reg : word_base;
        else
            found_start = word_base + PAGE_W'(first_set(win_r));
    end

    assign found_last = PAGE_W'(found_start + count_reg - CNT_W'(1));

    // Free range, clipped at the map end.
    assign free_sum  = (CNT_W+1)'(page_index) + (CNT_W+1)'(page_count);
    assign free_end  = (free_sum > (CNT_W+1)'(NUM_PAGES)) ? CNT_W'(NUM_PAGES)
                                                           : CNT_W'(free_sum);
    assign free_last = PAGE_W'(free_end - CNT_W'(1));

    // Bits of the current word covered by the run.
    assign mask_lo = (word_reg == rng_lo_reg[PAGE_W-1:BIT_W]) ?
                     rng_lo_reg[BIT_W-1:0] : '0;
    assign mask_hi = (word_reg == rng_last_reg[PAGE_W-1:BIT_W]) ?
                     rng_last_reg[BIT_W-1:0] : BIT_W'(WORD_W - 1);
    assign apply_mask = (ONES << mask_lo) & (ONES >> (BIT_W'(WORD_W - 1) - mask_hi));
    assign last_apply_word = (word_reg == rng_last_reg[PAGE_W-1:BIT_W]);

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        count_next      = count_reg;
        rng_lo_next     = rng_lo_reg;
        rng_last_next   = rng_last_reg;
        word_next       = word_reg;
        carry_next      = carry_reg;
        run_start_next  = run_start_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        raddr           = '0;
        mem_we          = 1'b0;
        mem_wdata       = '0;

        case (state_reg)
            S_IDLE:
            begin
                // Read word 0 now so the scan has it in its first cycle.
                raddr = '0;
                if (start)
                begin
                    op_next         = opcode;
                    count_next      = page_count;
                    word_next       = '0;
                    carry_next      = '0;
                    run_start_next  = '0;
                    res_status_next = ST_OK;
                    res_first_next  = '0;
                    if (opcode == OP_ALLOC)
                    begin
                        if ((page_count == '0) || (limit == '0))
                        begin
                            res_status_next = ST_FAIL;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        rng_lo_next   = page_index;
                        rng_last_next = free_last;
                        word_next     = page_index[PAGE_W-1:BIT_W];
                        state_next    = (page_count == '0) ? S_FINISH : S_APPLY;
                    end
                end
            end

            S_SCAN:
            begin
                // Prefetch the next word while this one is examined.
                raddr = word_reg + WADDR_W'(1);
                if (hit_carry || hit_inner)
                begin
                    res_first_next = found_start;
                    rng_lo_next    = found_start;
                    rng_last_next  = found_last;
                    word_next      = found_start[PAGE_W-1:BIT_W];
                    state_next     = S_APPLY;
                end
                else if (word_reg == last_scan_word)
                begin
                    res_status_next = ST_FAIL;
                    state_next      = S_FINISH;
                end
                else
                begin
                    word_next = word_reg + WADDR_W'(1);
                    if (used == '0)
                    begin
                        carry_next     = carry_reg + CNT_W'(WORD_W);
                        run_start_next = (carry_reg != '0) ? run_start_reg : word_base;
                    end
                    else
                    begin
                        carry_next     = CNT_W'(high_free);
                        run_start_next = word_base + PAGE_W'(WORD_W) - PAGE_W'(high_free);
                    end
                end
            end

            S_APPLY:
            begin
                raddr = word_reg;
                if (apply_mask == ONES)
                begin
                    // Whole word covered: write without reading.
                    mem_we    = 1'b1;
                    mem_wdata = (op_reg == OP_FREE) ? '0 : ONES;
                    if (last_apply_word)
                        state_next = S_FINISH;
                    else
                        word_next = word_reg + WADDR_W'(1);
                end
                else
                begin
                    state_next = S_APPLY_MOD;
                end
            end

            S_APPLY_MOD:
            begin
                raddr     = word_reg;
                mem_we    = 1'b1;
                mem_wdata = (op_reg == OP_FREE) ? (cur_word & ~apply_mask)
                                                : (cur_word | apply_mask);
                if (last_apply_word)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    word_next  = word_reg + WADDR_W'(1);
                    state_next = S_APPLY;
                end
            end

            S_FINISH:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State and control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            done_reg         <= 1'b0;
            usable_pages_reg <= '0;
            row_valid_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_FINISH);
            if (usable_pages_we)
                usable_pages_reg <= usable_pages;
            if (mem_we)
                row_valid_reg[word_reg] <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        count_reg      <= count_next;
        rng_lo_reg     <= rng_lo_next;
        rng_last_reg   <= rng_last_next;
        word_reg       <= word_next;
        carry_reg      <= carry_next;
        run_start_reg  <= run_start_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        if (state_reg == S_FINISH)
        begin
            status_reg     <= res_status_reg;
            first_page_reg <= (res_status_reg == ST_FAIL) ? '0 : res_first_reg;
        end
    end

    // Map RAM, one read and one write port, registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            map_mem[word_reg] <= mem_wdata;
        rd_data_reg <= map_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else
            rd_valid_reg <= row_valid_reg[raddr];
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_done_after_busy : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a command in flight");

    a_fail_zero_page : assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FAIL)) |-> (first_page == '0))
        else $error("failed allocation reports a nonzero page");

    a_write_in_apply : assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == S_APPLY) || (state_reg == S_APPLY_MOD)))
        else $error("map write outside the mark phase");

    a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");
`endif

endmodule

`default_nettype wire
